// ===== hw/rtl/rbf_pkg.sv =====
// rbf_pkg: shared constants, codes and controller/datapath types
// for the ring buffer fifo; no dependencies
package rbf_pkg;

    localparam int STORE_DEPTH  = 16;
    localparam int ITEM_BITS    = 64;

    localparam int MODE_W       = 3;
    localparam int ITEM_FIELD_W = 64;
    localparam int STATUS_W     = 2;
    localparam int CAP_W        = 5;

    localparam int SLOT_W       = $clog2(STORE_DEPTH);
    localparam int COUNT_W      = $clog2(STORE_DEPTH + 1);
    localparam int CAP_CMP_W    = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam mode_t MODE_PUT   = 3'd0;
    localparam mode_t MODE_GET   = 3'd1;
    localparam mode_t MODE_PEEK  = 3'd2;
    localparam mode_t MODE_POP   = 3'd3;
    localparam mode_t MODE_CLEAR = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // command from controller to datapath for one accepted operation
    typedef struct packed {
        logic    exec;
        logic    do_write;
        logic    do_remove;
        logic    do_clear;
        logic    read_ok;
        status_t status;
    } rbf_cmd_t;

    // occupancy flags from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } rbf_flags_t;

endpackage

// ===== hw/rtl/rbf_if.sv =====
// rbf_in_if and rbf_out_if: valid/ready channels for operations and results
// depends on rbf_pkg
interface rbf_in_if
    import rbf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [ITEM_FIELD_W-1:0] item_in;

    modport source (output valid, output mode, output item_in, input ready);
    modport sink   (input valid, input mode, input item_in, output ready);
endinterface

interface rbf_out_if
    import rbf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [ITEM_FIELD_W-1:0] item_out;
    logic [COUNT_W-1:0]      occupancy;

    modport source (output valid, output status, output item_out, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input item_out, input occupancy,
                    output ready);
endinterface

// ===== hw/rtl/rbf_ctrl.sv =====
// rbf_ctrl: handshake state machine and operation decode
// depends on rbf_pkg
module rbf_ctrl
    import rbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  mode_t      mode,
    output logic       out_valid,
    input  logic       out_ready,
    input  rbf_flags_t flags,
    output rbf_cmd_t   cmd
);

    typedef enum logic {S_IDLE, S_RESULT} state_t;

    state_t state_reg, state_next;
    logic   accept;

    // a waiting result may leave in the same cycle a new transfer comes in
    assign in_ready  = (state_reg == S_IDLE) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_RESULT);

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = S_RESULT;
        end
        else if (state_reg == S_RESULT && out_ready)
        begin
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.exec      = accept;
        cmd.status    = ST_OK;
        if (accept)
        begin
            unique case (mode)
                MODE_PUT:
                begin
                    if (flags.full)
                        cmd.status = ST_FULL;
                    else
                        cmd.do_write = 1'b1;
                end
                MODE_GET, MODE_PEEK, MODE_POP:
                begin
                    if (flags.empty)
                    begin
                        cmd.status = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.do_remove = (mode != MODE_PEEK);
                        cmd.read_ok   = (mode != MODE_POP);
                    end
                end
                MODE_CLEAR:
                begin
                    cmd.do_clear = 1'b1;
                end
                default:
                begin
                    cmd.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/rbf_datapath.sv =====
// rbf_datapath: item store, write slot, count, capacity register and result register
// depends on rbf_pkg
module rbf_datapath
    import rbf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CAP_W-1:0]        cfg_wr_data,
    input  logic [ITEM_FIELD_W-1:0] item_in,
    input  rbf_cmd_t                cmd,
    output rbf_flags_t              flags,
    output status_t                 status,
    output logic [ITEM_FIELD_W-1:0] item_out,
    output logic [COUNT_W-1:0]      occupancy
);

    logic [ITEM_BITS-1:0]    store [STORE_DEPTH];

    logic [CAP_W-1:0]        cap_reg;
    logic [SLOT_W-1:0]       wslot_reg, wslot_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    status_t                 status_reg;
    logic [ITEM_FIELD_W-1:0] item_out_reg;
    logic [COUNT_W-1:0]      occ_reg;

    logic [CAP_CMP_W-1:0]    cap_wide;
    logic [COUNT_W-1:0]      eff_cap;
    logic [COUNT_W:0]        rd_sum;
    logic [COUNT_W:0]        rd_slot;
    logic [SLOT_W-1:0]       rd_idx;
    logic [COUNT_W:0]        ws_inc;

    // register value 0 acts as 1, above the store depth acts as the depth
    always_comb
    begin
        cap_wide = CAP_CMP_W'(cap_reg);
        priority if (cap_wide == '0)
            eff_cap = COUNT_W'(1);
        else if (cap_wide > CAP_CMP_W'(STORE_DEPTH))
            eff_cap = COUNT_W'(STORE_DEPTH);
        else
            eff_cap = COUNT_W'(cap_wide);
    end

    assign flags.full  = (count_reg >= eff_cap);
    assign flags.empty = (count_reg == '0);

    // oldest slot: write slot minus count, wrapped at the capacity
    always_comb
    begin
        rd_sum  = (COUNT_W + 1)'(eff_cap) + (COUNT_W + 1)'(wslot_reg)
                  - (COUNT_W + 1)'(count_reg);
        rd_slot = (rd_sum >= (COUNT_W + 1)'(eff_cap)) ? rd_sum - (COUNT_W + 1)'(eff_cap)
                                                        : rd_sum;
        rd_idx  = rd_slot[SLOT_W-1:0];
    end

    always_comb
    begin
        ws_inc     = (COUNT_W + 1)'(wslot_reg) + (COUNT_W + 1)'(1);
        wslot_next = wslot_reg;
        count_next = count_reg;
        if (cfg_wr_en || cmd.do_clear)
        begin
            wslot_next = '0;
            count_next = '0;
        end
        else if (cmd.do_write)
        begin
            wslot_next = (ws_inc >= (COUNT_W + 1)'(eff_cap)) ? '0 : ws_inc[SLOT_W-1:0];
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.do_remove)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            wslot_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            wslot_reg <= wslot_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write)
            store[wslot_reg] <= item_in[ITEM_BITS-1:0];
    end

    // result register, loaded on each transfer in
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg   <= cmd.status;
            occ_reg      <= count_next;
            item_out_reg <= cmd.read_ok ? ITEM_FIELD_W'(store[rd_idx]) : '0;
        end
    end

    assign status    = status_reg;
    assign item_out  = item_out_reg;
    assign occupancy = occ_reg;

endmodule

// ===== hw/rtl/ring_buffer_fifo.sv =====
// ring_buffer_fifo: top level joining rbf_ctrl and rbf_datapath
// depends on rbf_pkg, rbf_in_if, rbf_out_if, rbf_ctrl, rbf_datapath
//
// Circular FIFO of 16 x 64-bit items taking one operation (put, get, peek,
// pop, clear) per transfer on in_ch and giving one result (status, item,
// occupancy) per operation on out_ch. The result appears in the output
// register the cycle after the operation's transfer, and a new operation is
// taken in the same cycle the waiting result is taken, so one operation a
// cycle is sustained while out_ch is ready; the result register is the one
// stage. Writing the capacity register (0 acts as 1, above 16 acts as 16)
// also empties the FIFO; write it only while no result is pending.
module ring_buffer_fifo
    import rbf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    rbf_in_if.sink           in_ch,
    rbf_out_if.source        out_ch
);

    rbf_cmd_t   cmd;
    rbf_flags_t flags;

    rbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .mode      (in_ch.mode),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    rbf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_in     (in_ch.item_in),
        .cmd         (cmd),
        .flags       (flags),
        .status      (out_ch.status),
        .item_out    (out_ch.item_out),
        .occupancy   (out_ch.occupancy)
    );

endmodule

// ===== hw/rtl/rbf_checker.sv =====
// rbf_assertions: port-level assertions for ring_buffer_fifo, bound to the top level
// depends on rbf_pkg and ring_buffer_fifo
module rbf_assertions
    import rbf_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [MODE_W-1:0]       mode,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [STATUS_W-1:0]     status,
    input logic [ITEM_FIELD_W-1:0] item_out,
    input logic [COUNT_W-1:0]      occupancy
);

    // a result not taken stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> item_out == '0)
        else $error("item returned with a failing status");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= COUNT_W'(STORE_DEPTH))
        else $error("occupancy above store depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode == MODE_CLEAR
        |=> out_valid && occupancy == '0 && status == ST_OK)
        else $error("clear did not empty the fifo");

    a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy != '0)
        else $error("full reported with no items stored");

endmodule

bind ring_buffer_fifo rbf_assertions u_rbf_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .mode      (in_ch.mode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .item_out  (out_ch.item_out),
    .occupancy (out_ch.occupancy)
);

// ===== verif/rbf_checker.sv =====
// rbf_checker: shadow model and result comparison for ring_buffer_fifo
// watches the configuration port and both channels; depends on rbf_pkg, rbf_if
module rbf_checker
    import rbf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    rbf_in_if                in_ch,
    rbf_out_if               out_ch,
    output int               fail_count,
    output int               pending,
    output int               results_checked,
    output int               full_hits,
    output int               empty_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        status_t                 status;
        logic [ITEM_FIELD_W-1:0] item;
        logic [COUNT_W-1:0]      occupancy;
    } fifo_result_t;

    fifo_result_t            awaited_results[$];
    logic [ITEM_FIELD_W-1:0] shadow_store[STORE_DEPTH];
    int unsigned             shadow_wslot;
    int unsigned             shadow_count;
    logic [CAP_W-1:0]        shadow_cap;

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        full_hits       = 0;
        empty_hits      = 0;
    end

    task automatic report_mismatch(string what, logic [ITEM_FIELD_W-1:0] got,
                                   logic [ITEM_FIELD_W-1:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch, %s at result %0d: got 0x%0h, want 0x%0h",
                     $realtime, what, results_checked, got, want);
        fail_count++;
    endtask

    // applies one operation to the shadow state and returns its result
    function automatic fifo_result_t fifo_step_outcome(mode_t op,
                                                       logic [ITEM_FIELD_W-1:0] data);
        fifo_result_t res;
        int unsigned  cap;
        int unsigned  rd;
        cap = (shadow_cap == 0) ? 1 : ((shadow_cap > STORE_DEPTH) ? STORE_DEPTH : shadow_cap);
        res.status = ST_OK;
        res.item   = '0;
        case (op)
            MODE_PUT:
            begin
                if (shadow_count >= cap)
                    res.status = ST_FULL;
                else
                begin
                    shadow_store[shadow_wslot % STORE_DEPTH] = data;
                    shadow_count++;
                    shadow_wslot++;
                    if (shadow_wslot >= cap)
                        shadow_wslot = 0;
                end
            end
            MODE_GET, MODE_PEEK:
            begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    // oldest slot sits count places behind the write slot
                    rd = cap + shadow_wslot - shadow_count;
                    if (rd >= cap)
                        rd -= cap;
                    res.item = shadow_store[rd % STORE_DEPTH];
                    if (op == MODE_GET)
                        shadow_count--;
                end
            end
            MODE_POP:
            begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                    shadow_count--;
            end
            MODE_CLEAR:
            begin
                shadow_count = 0;
                shadow_wslot = 0;
            end
            default:
            begin
            end
        endcase
        res.occupancy = COUNT_W'(shadow_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fifo_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            shadow_wslot = 0;
            shadow_count = 0;
            shadow_cap   = CAP_RESET;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with none awaited", out_ch.item_out, '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_ch.status !== want.status)
                        report_mismatch("status", out_ch.status, want.status);
                    if (out_ch.item_out !== want.item)
                        report_mismatch("item_out", out_ch.item_out, want.item);
                    if (out_ch.occupancy !== want.occupancy)
                        report_mismatch("occupancy", out_ch.occupancy, want.occupancy);
                    if (want.status == ST_FULL)
                        full_hits++;
                    if (want.status == ST_EMPTY)
                        empty_hits++;
                end
                results_checked++;
            end
            // a capacity write also empties the fifo
            if (cfg_wr_en)
            begin
                shadow_cap   = cfg_wr_data;
                shadow_wslot = 0;
                shadow_count = 0;
            end
            if (in_ch.valid && in_ch.ready)
                awaited_results.push_back(fifo_step_outcome(mode_t'(in_ch.mode),
                                                            in_ch.item_in));
        end
        pending = awaited_results.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: stimulus, handshake idling and verdict for ring_buffer_fifo
// depends on rbf_pkg, rbf_if, ring_buffer_fifo and rbf_checker
module tb_top;
    import rbf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    RANDOM_ITEMS     = 1400;
    localparam int    CYCLE_LIMIT      = 400000;
    localparam mode_t MODE_SPARE_FIRST = 3'd5;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    int fail_count;
    int pending;
    int results_checked;
    int full_hits;
    int empty_hits;
    int ops_sent    = 0;
    int cap_writes  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    rbf_in_if  in_ch();
    rbf_out_if out_ch();

    ring_buffer_fifo dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    rbf_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .full_hits       (full_hits),
        .empty_hits      (empty_hits)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("** ring_buffer_fifo: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // result side: random back-pressure after each transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_op(mode_t op, logic [ITEM_FIELD_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= op;
        in_ch.item_in <= data;
        do
            @(posedge clk);
        while (!in_ch.ready);
        ops_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_writes++;
    endtask

    function automatic logic [ITEM_FIELD_W-1:0] random_item();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic mode_t pick_mode(int put_pct);
        int r;
        if ($urandom_range(0, 99) < put_pct)
            return MODE_PUT;
        r = $urandom_range(0, 99);
        if (r < 50)
            return MODE_GET;
        if (r < 72)
            return MODE_PEEK;
        if (r < 90)
            return MODE_POP;
        if (r < 95)
            return MODE_CLEAR;
        return mode_t'(MODE_SPARE_FIRST + $urandom_range(0, 2));
    endfunction

    initial
    begin
        int               sent;
        int               phase;
        int               len;
        int               put_pct;
        logic [CAP_W-1:0] cap;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_PUT;
        in_ch.item_in = '0;
        out_ch.ready  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: empty cases, extremes of the item, spare modes
        send_op(MODE_GET, '1);
        send_op(MODE_PEEK, '0);
        send_op(MODE_POP, '0);
        send_op(MODE_PUT, '0);
        send_op(MODE_PUT, '1);
        send_op(MODE_PEEK, '0);
        send_op(MODE_GET, '0);
        send_op(MODE_GET, '0);
        send_op(MODE_PUT, 64'hA5A5_5A5A_0123_4567);
        send_op(MODE_CLEAR, '1);
        send_op(MODE_SPARE_FIRST, '1);
        send_op(mode_t'(MODE_SPARE_FIRST + 1), '0);
        send_op(mode_t'(MODE_SPARE_FIRST + 2), '1);

        // two entries: fill, refuse, wrap the slots round
        set_capacity(CAP_W'(2));
        send_op(MODE_PUT, 64'h1111_2222_3333_4444);
        send_op(MODE_PUT, 64'h8000_0000_0000_0001);
        send_op(MODE_PUT, 64'hDEAD_BEEF_CAFE_F00D);
        send_op(MODE_GET, '0);
        send_op(MODE_PUT, 64'h7FFF_FFFF_FFFF_FFFE);
        send_op(MODE_GET, '0);
        send_op(MODE_GET, '0);
        send_op(MODE_GET, '0);

        // zero capacity behaves as a single entry
        set_capacity('0);
        send_op(MODE_PUT, 64'h0F0F_0F0F_F0F0_F0F0);
        send_op(MODE_PUT, 64'h1234_5678_9ABC_DEF0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                0:       cap = CAP_W'(1);
                1:       cap = '1;
                2:       cap = '0;
                3:       cap = CAP_W'(2);
                4:       cap = CAP_W'(17);
                5:       cap = CAP_W'(16);
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            set_capacity(cap);
            // vary the mix so some phases fill up and others run dry
            case (phase % 4)
                0:       put_pct = 75;
                1:       put_pct = 50;
                2:       put_pct = 30;
                default: put_pct = $urandom_range(20, 80);
            endcase
            calm = ($urandom_range(0, 3) == 0);
            len  = $urandom_range(40, 120);
            for (int i = 0; i < len; i++)
            begin
                send_op(pick_mode(put_pct), random_item());
                sent++;
            end
            phase++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (4) @(posedge clk);
        $display("%0d operations over %0d capacity settings, %0d results checked",
                 ops_sent, cap_writes, results_checked);
        $display("%0d puts refused on full, %0d empty reports", full_hits, empty_hits);
        if (fail_count == 0 && pending == 0)
            $display("** ring_buffer_fifo: PASSED **");
        else
            $display("** ring_buffer_fifo: FAILED **");
        $finish;
    end

endmodule
